>>> rtl/core/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Request/response types and codes shared by the snapshot slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_RANGE      = 3'd2;
	localparam logic [2:0] ST_MISMATCH   = 3'd3;
	localparam logic [2:0] ST_ZERO_OWNER = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [31:0] owner_id;
		logic [47:0] commit_number;
		logic [5:0]  slot_handle;
	} req_t;

	typedef struct packed {
		logic [5:0]  granted_slot;
		logic [47:0] given_commit_number;
		logic [2:0]  status;
		logic [6:0]  slots_in_use;
		logic [31:0] releases_seen;
	} rsp_t;

endpackage

>>> rtl/core/ssa_owner_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_owner_ram
// Owner table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssa_owner_ram #(
	parameter int SLOTS = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [31:0]              rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [31:0]              wr_data
);

	logic [31:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/snapshot_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_slot_allocator
// Low-watermark snapshot slot allocator over an owner table in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Each
//   request yields exactly one response, shown on rsp for one cycle with done
//   high; the receiver cannot stall it and must take it then.
//   Begin: a zero owner is answered straight from idle; otherwise slots are
//   probed upward from the watermark until a free slot or the used count is
//   reached. One table probe per cycle, set by the single RAM read port.
//   End: out of range or zero owner is answered straight from idle; otherwise
//   a compare and clear; releasing the top slot also probes each slot below
//   it on the way down until an occupied one is found.
//   done rises the cycle after the last step; busy is low in that cycle.
//   Reset clears used count, watermark and release counter. The owner table
//   needs no clearing pass: read data is used only for entries below the used
//   count, and each of those has been written since reset.
// ----------------------------------------------------------------------------
module snapshot_slot_allocator #(
	parameter int SLOTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ssa_pkg::req_t req,
	output logic          done,
	output ssa_pkg::rsp_t rsp
);

	import ssa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef enum logic [1:0] {IDLE, SCAN, CHECK, SHRINK} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] low_q, low_d;
	logic [31:0]   rel_q, rel_d;
	logic [CW-1:0] ptr_q, ptr_d;
	req_t          req_q;
	rsp_t          rsp_q, rsp_d;
	logic          done_q;

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [31:0]   rd_data, wr_data;

	logic          fin;
	logic [CW-1:0] fin_slot;
	logic [47:0]   fin_cn;
	logic [2:0]    fin_st;
	logic [CW-1:0] hc;

	ssa_owner_ram #(
		.SLOTS(SLOTS)
	) u_ram (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign busy = (state_q != IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
	assign hc   = CW'(req_q.slot_handle);

	always_comb begin
		state_d  = state_q;
		used_d   = used_q;
		low_d    = low_q;
		rel_d    = rel_q;
		ptr_d    = ptr_q;
		rd_en    = 1'b0;
		rd_addr  = IW'(ptr_q);
		wr_en    = 1'b0;
		wr_addr  = IW'(ptr_q);
		wr_data  = '0;
		fin      = 1'b0;
		fin_slot = '0;
		fin_cn   = '0;
		fin_st   = ST_OK;
		case (state_q)
			IDLE: begin
				if (start) begin
					if (req.kind == KIND_BEGIN) begin
						if (req.owner_id == 32'd0) begin
							fin    = 1'b1;
							fin_st = ST_ZERO_OWNER;
						end else begin
							ptr_d   = low_q;
							rd_en   = 1'b1;
							rd_addr = IW'(low_q);
							state_d = SCAN;
						end
					end else begin
						fin_slot = CW'(req.slot_handle);
						if (EW'(req.slot_handle) >= EW'(used_q)) begin
							fin    = 1'b1;
							fin_st = ST_RANGE;
						end else if (req.owner_id == 32'd0) begin
							fin    = 1'b1;
							fin_st = ST_ZERO_OWNER;
						end else begin
							rd_en   = 1'b1;
							rd_addr = IW'(req.slot_handle);
							state_d = CHECK;
						end
					end
				end
			end
			SCAN: begin
				if (ptr_q < used_q && rd_data == 32'd0) begin
					wr_en    = 1'b1;
					wr_addr  = IW'(ptr_q);
					wr_data  = req_q.owner_id;
					low_d    = ptr_q + 1'b1;
					fin      = 1'b1;
					fin_slot = ptr_q;
					fin_cn   = req_q.commit_number;
				end else if (ptr_q < used_q) begin
					ptr_d   = ptr_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = IW'(ptr_q + 1'b1);
				end else if (used_q == SLOTS_C) begin
					fin    = 1'b1;
					fin_st = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					wr_addr  = IW'(used_q);
					wr_data  = req_q.owner_id;
					used_d   = used_q + 1'b1;
					low_d    = used_q + 1'b1;
					fin      = 1'b1;
					fin_slot = used_q;
					fin_cn   = req_q.commit_number;
				end
			end
			CHECK: begin
				fin_slot = hc;
				if (rd_data != req_q.owner_id) begin
					fin    = 1'b1;
					fin_st = ST_MISMATCH;
				end else begin
					wr_en   = 1'b1;
					wr_addr = IW'(hc);
					wr_data = '0;
					rel_d   = rel_q + 32'd1;
					if (low_q > hc) begin
						low_d = hc;
					end
					if (hc + 1'b1 == used_q && hc != '0) begin
						ptr_d   = hc;
						rd_en   = 1'b1;
						rd_addr = IW'(hc - 1'b1);
						state_d = SHRINK;
					end else begin
						if (hc + 1'b1 == used_q) begin
							used_d = '0;
						end
						fin = 1'b1;
					end
				end
			end
			SHRINK: begin
				fin_slot = hc;
				if (rd_data == 32'd0) begin
					if (ptr_q == CW'(1)) begin
						used_d = '0;
						fin    = 1'b1;
					end else begin
						ptr_d   = ptr_q - 1'b1;
						rd_en   = 1'b1;
						rd_addr = IW'(ptr_q - CW'(2));
					end
				end else begin
					used_d = ptr_q;
					fin    = 1'b1;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
		if (fin) begin
			state_d = IDLE;
		end
		rsp_d                     = rsp_q;
		rsp_d.granted_slot        = 6'(fin_slot);
		rsp_d.given_commit_number = fin_cn;
		rsp_d.status              = fin_st;
		rsp_d.slots_in_use        = 7'(used_d);
		rsp_d.releases_seen       = rel_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			used_q  <= '0;
			low_q   <= '0;
			rel_q   <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			low_q   <= low_d;
			rel_q   <= rel_d;
			ptr_q   <= ptr_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the snapshot slot allocator.
// Begin/end requests go out from a queue through the start/busy handshake
// with random idle bursts. Each accepted request runs through a slot table
// model, and every done response is compared field by field with the
// oldest predicted response. A second copy of the table tracks the planned
// stream, so that the stimulus can release slots that are really occupied.
// ----------------------------------------------------------------------------
module tb;

	import ssa_pkg::*;

	localparam int SLOTS      = 64;
	localparam int ITEMS      = 1550;
	localparam int QUIET_TAIL = 150;
	localparam int LIMIT      = 900_000;
	localparam int VIEW_PLAN  = 0;
	localparam int VIEW_CHECK = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// two copies of the slot table: planned stream and accepted stream
	logic [31:0] owner_tab [2][SLOTS];
	int          used_cnt [2];
	int          low_mark [2];
	logic [31:0] rel_cnt [2];

	req_t pending [$];
	rsp_t expected_rsp [$];
	int   planned = 0;
	int   idle_left = 0;
	int   errors = 0;
	int   rsp_seen = 0;
	int   cycles = 0;
	rsp_t predicted;
	rsp_t want;

	snapshot_slot_allocator #(.SLOTS(SLOTS)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic rsp_t slot_table_step(input int v, input req_t r);
		rsp_t o;
		int   s;
		int   t;
		o = '0;
		if (r.kind == KIND_BEGIN) begin
			if (r.owner_id == 32'd0) begin
				o.status = ST_ZERO_OWNER;
			end else begin
				s = low_mark[v];
				while (s < used_cnt[v] && owner_tab[v][s] != 32'd0)
					s++;
				if (s >= used_cnt[v] && used_cnt[v] >= SLOTS) begin
					o.status = ST_FULL;
				end else begin
					if (s >= used_cnt[v]) begin
						s = used_cnt[v];
						used_cnt[v] = s + 1;
					end
					owner_tab[v][s] = r.owner_id;
					low_mark[v] = s + 1;
					o.granted_slot = 6'(s);
					o.given_commit_number = r.commit_number;
					o.status = ST_OK;
				end
			end
		end else begin
			s = int'(r.slot_handle);
			o.granted_slot = r.slot_handle;
			if (s >= used_cnt[v]) begin
				o.status = ST_RANGE;
			end else if (r.owner_id == 32'd0) begin
				o.status = ST_ZERO_OWNER;
			end else if (owner_tab[v][s] != r.owner_id) begin
				o.status = ST_MISMATCH;
			end else begin
				if (low_mark[v] > s)
					low_mark[v] = s;
				owner_tab[v][s] = 32'd0;
				if (s + 1 == used_cnt[v]) begin
					t = s;
					while (t > 0 && owner_tab[v][t - 1] == 32'd0)
						t--;
					used_cnt[v] = t;
				end
				rel_cnt[v] = rel_cnt[v] + 32'd1;
				o.status = ST_OK;
			end
		end
		o.slots_in_use = 7'(used_cnt[v]);
		o.releases_seen = rel_cnt[v];
		return o;
	endfunction

	// a begin on the planned stream would now see a full table
	function automatic bit plan_full();
		int s;
		if (used_cnt[VIEW_PLAN] < SLOTS)
			return 1'b0;
		for (s = low_mark[VIEW_PLAN]; s < SLOTS; s++)
			if (owner_tab[VIEW_PLAN][s] == 32'd0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] rand_owner();
		logic [31:0] o;
		o = 32'($urandom);
		while (o == 32'd0)
			o = 32'($urandom);
		return o;
	endfunction

	function automatic logic [47:0] rand_commit();
		logic [47:0] c;
		c[31:0] = 32'($urandom);
		c[47:32] = 16'($urandom);
		return c;
	endfunction

	task automatic push_req(input logic kind, input logic [31:0] owner,
			input logic [47:0] cn, input logic [5:0] handle);
		req_t r;
		r.kind = kind;
		r.owner_id = owner;
		r.commit_number = cn;
		r.slot_handle = handle;
		pending.push_back(r);
		void'(slot_table_step(VIEW_PLAN, r));
		planned++;
	endtask

	task automatic push_begin(input logic [31:0] owner, input logic [47:0] cn);
		push_req(KIND_BEGIN, owner, cn, 6'($urandom));
	endtask

	task automatic push_end(input logic [31:0] owner, input logic [5:0] handle);
		push_req(KIND_END, owner, rand_commit(), handle);
	endtask

	// free a used slot, owner bad iff wrong_owner; top slot is always used
	task automatic push_release(input bit top_only, input bit wrong_owner);
		int          n;
		int          k;
		logic [31:0] o;
		n = used_cnt[VIEW_PLAN];
		if (n == 0) begin
			push_begin(rand_owner(), rand_commit());
		end else begin
			k = top_only ? n - 1 : $urandom_range(0, n - 1);
			while (owner_tab[VIEW_PLAN][k] == 32'd0)
				k = (k + 1) % n;
			o = owner_tab[VIEW_PLAN][k];
			if (wrong_owner)
				o = o ^ (32'd1 << $urandom_range(0, 31));
			push_end(o, 6'(k));
		end
	endtask

	task automatic plan_mixed(input int len);
		int i;
		int pick;
		for (i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				push_begin(rand_owner(), rand_commit());
			else if (pick < 80)
				push_release(1'b0, 1'b0);
			else if (pick < 85)
				push_begin(32'd0, rand_commit());
			else if (pick < 90)
				push_end(32'd0, 6'($urandom));
			else if (pick < 95)
				push_end(32'($urandom), 6'($urandom));
			else
				push_release(1'b0, 1'b1);
		end
	endtask

	task automatic plan_stimulus();
		int i;
		int mode;
		for (i = 0; i < 2; i++) begin
			used_cnt[i] = 0;
			low_mark[i] = 0;
			rel_cnt[i] = 32'd0;
			for (int j = 0; j < SLOTS; j++)
				owner_tab[i][j] = 32'd0;
		end

		push_begin(32'd0, 48'h1234_5678_9abc);
		push_end(32'd1, 6'd0);
		push_end(32'hffff_ffff, 6'd63);
		push_begin(32'hffff_ffff, 48'hffff_ffff_ffff);
		push_begin(32'd1, 48'd0);
		push_begin(32'h8000_0000, 48'h8000_0000_0000);
		push_begin(32'h5a5a_a5a5, 48'h5555_aaaa_5555);
		push_end(32'd2, 6'd0);
		push_end(32'd0, 6'd0);
		push_end(32'd7, 6'd4);
		push_end(32'hffff_ffff, 6'd0);
		push_begin(32'h7fff_ffff, 48'h7fff_ffff_ffff);
		push_end(32'd1, 6'd1);
		push_end(32'h8000_0000, 6'd2);
		push_end(32'h5a5a_a5a5, 6'd3);
		push_end(32'd1, 6'd1);
		push_end(32'h7fff_ffff, 6'd0);
		push_begin(32'h0000_ffff, 48'h0000_ffff_0000);

		while (planned < ITEMS) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				plan_mixed($urandom_range(8, 40));
			end else if (mode < 8) begin
				// fill up, then hit the full table
				while (!plan_full())
					push_begin(rand_owner(), rand_commit());
				for (i = 0; i < $urandom_range(1, 3); i++)
					push_begin(rand_owner(), rand_commit());
			end else begin
				// drain, partly from the top to exercise shrinking
				while (used_cnt[VIEW_PLAN] > 0)
					push_release(($urandom_range(0, 1) == 0), 1'b0);
			end
		end
	endtask

	task automatic report(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("ERROR: response %0d %s: got %0h, expected %0h",
			rsp_seen, what, got, exp_val);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predicted = slot_table_step(VIEW_CHECK, req);
				expected_rsp.push_back(predicted);
			end
			if (!start || !busy) begin
				if (idle_left != 0) begin
					start <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
					start <= 1'b0;
					idle_left <= $urandom_range(0, 2);
				end else if (pending.size() != 0) begin
					start <= 1'b1;
					req <= pending.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report("unexpected response", 64'(rsp), 64'd0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.granted_slot !== want.granted_slot)
					report("granted_slot", 64'(rsp.granted_slot), 64'(want.granted_slot));
				if (rsp.given_commit_number !== want.given_commit_number)
					report("given_commit_number", 64'(rsp.given_commit_number),
						64'(want.given_commit_number));
				if (rsp.status !== want.status)
					report("status", 64'(rsp.status), 64'(want.status));
				if (rsp.slots_in_use !== want.slots_in_use)
					report("slots_in_use", 64'(rsp.slots_in_use), 64'(want.slots_in_use));
				if (rsp.releases_seen !== want.releases_seen)
					report("releases_seen", 64'(rsp.releases_seen), 64'(want.releases_seen));
			end
			rsp_seen <= rsp_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		plan_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || start || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ssa_pkg.sv
rtl/core/ssa_owner_ram.sv
rtl/core/snapshot_slot_allocator.sv
tb/sv/tb.sv
